[hdl/scl_pkg.sv]
// Shared types, constants and command tables for the command line parser.
`timescale 1ns / 1ps
package scl_pkg;

  // Longest line length tracked; the byte count saturates here.
  localparam int MAX_LINE   = 1024;
  localparam int LINE_POS_W = $clog2(MAX_LINE + 1);

  localparam logic [7:0] NEWLINE  = 8'd10;
  localparam logic [7:0] ASCII_0  = "0";
  localparam logic [7:0] LETTER_F = "F";
  localparam logic [7:0] LETTER_C = "C";

  // Byte index where the scale letter sits, and where period digits begin.
  localparam int SCALE_POS  = 6;
  localparam int PERIOD_POS = 7;

  localparam int NUM_CMDS   = 6;
  localparam int CMD_SCALE  = 0;
  localparam int CMD_PERIOD = 1;
  localparam int CMD_STOP   = 2;
  localparam int CMD_START  = 3;
  localparam int CMD_LOG    = 4;
  localparam int CMD_OFF    = 5;

  localparam logic [7:0] CMD_TEXT [NUM_CMDS][8] = '{
    '{"S", "C", "A", "L", "E", "=", 8'd0, 8'd0},
    '{"P", "E", "R", "I", "O", "D", "=", 8'd0},
    '{"S", "T", "O", "P", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"S", "T", "A", "R", "T", 8'd0, 8'd0, 8'd0},
    '{"L", "O", "G", " ", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"O", "F", "F", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };
  localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{4'd6, 4'd7, 4'd4, 4'd5, 4'd4, 4'd3};
  localparam logic [NUM_CMDS-1:0] CMD_EXACT = 6'b101100;

  // Queue between the byte front end and the settings back end.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int PERIOD_W = 31;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_SCALE    = 3'd1,
    EV_PERIOD   = 3'd2,
    EV_REJECTED = 3'd3,
    EV_STOP     = 3'd4,
    EV_START    = 3'd5,
    EV_LOG      = 3'd6,
    EV_OFF      = 3'd7
  } event_t;

  // One classified line, as handed from the front end to the back end.
  typedef struct packed {
    event_t                ev;
    logic                  celsius;
    logic [PERIOD_W-1:0]   period;
  } line_cmd_t;

endpackage

[hdl/scl_front.sv]
// Byte front end: matches commands byte by byte and classifies each line.
`timescale 1ns / 1ps
module scl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_cmd_byte,
  input  logic              fifo_full,
  output logic              push,
  output scl_pkg::line_cmd_t push_cmd
);
  import scl_pkg::*;

  logic [LINE_POS_W-1:0] pos_r, pos_nxt;
  logic [NUM_CMDS-1:0]   flags_r, flags_nxt;
  logic [7:0]            letter_r, letter_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic                  halted_r, halted_nxt;

  logic                  accept;
  logic                  is_nl;
  logic [NUM_CMDS-1:0]   matched;
  line_cmd_t             cmd;

  // Halted: swallow everything. Otherwise hold off only when the queue is full.
  assign in_ready = halted_r || !fifo_full;
  assign accept   = in_valid && in_ready && !halted_r;
  assign is_nl    = (in_cmd_byte == NEWLINE);

  always_comb begin
    for (int k = 0; k < NUM_CMDS; k++) begin
      matched[k] = flags_r[k] && (pos_r >= LINE_POS_W'(CMD_LEN[k]));
    end
  end

  // End-of-line classification, first match wins.
  always_comb begin
    cmd.ev      = EV_IGNORED;
    cmd.celsius = 1'b0;
    cmd.period  = acc_r[PERIOD_W-1:0];
    if (matched[CMD_SCALE]) begin
      if (letter_r == LETTER_F) begin
        cmd.ev      = EV_SCALE;
        cmd.celsius = 1'b0;
      end else if (letter_r == LETTER_C) begin
        cmd.ev      = EV_SCALE;
        cmd.celsius = 1'b1;
      end
    end else if (matched[CMD_PERIOD]) begin
      if (acc_r == 32'd0 || acc_r[31]) begin
        cmd.ev = EV_REJECTED;
      end else begin
        cmd.ev = EV_PERIOD;
      end
    end else if (matched[CMD_STOP]) begin
      cmd.ev = EV_STOP;
    end else if (matched[CMD_START]) begin
      cmd.ev = EV_START;
    end else if (matched[CMD_LOG]) begin
      cmd.ev = EV_LOG;
    end else if (matched[CMD_OFF]) begin
      cmd.ev = EV_OFF;
    end
  end

  assign push     = accept && is_nl;
  assign push_cmd = cmd;

  always_comb begin
    pos_nxt    = pos_r;
    flags_nxt  = flags_r;
    letter_nxt = letter_r;
    acc_nxt    = acc_r;
    halted_nxt = halted_r;
    if (accept) begin
      if (is_nl) begin
        pos_nxt    = '0;
        flags_nxt  = '1;
        letter_nxt = '0;
        acc_nxt    = '0;
        if (cmd.ev == EV_OFF) begin
          halted_nxt = 1'b1;
        end
      end else begin
        for (int k = 0; k < NUM_CMDS; k++) begin
          if (flags_r[k]) begin
            if (pos_r < LINE_POS_W'(CMD_LEN[k])) begin
              if (in_cmd_byte != CMD_TEXT[k][pos_r[2:0]]) begin
                flags_nxt[k] = 1'b0;
              end
            end else if (CMD_EXACT[k]) begin
              flags_nxt[k] = 1'b0;
            end
          end
        end
        if (pos_r == LINE_POS_W'(SCALE_POS)) begin
          letter_nxt = in_cmd_byte;
        end
        // acc*10 + byte - '0', wrapping at 32 bits
        if (pos_r >= LINE_POS_W'(PERIOD_POS)) begin
          acc_nxt = (acc_r << 3) + (acc_r << 1) + {24'd0, in_cmd_byte} - {24'd0, ASCII_0};
        end
        if (pos_r < LINE_POS_W'(MAX_LINE)) begin
          pos_nxt = pos_r + LINE_POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      flags_r  <= '1;
      letter_r <= '0;
      acc_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      flags_r  <= flags_nxt;
      letter_r <= letter_nxt;
      acc_r    <= acc_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

[hdl/scl_fifo.sv]
// Short queue of classified lines between front end and back end.
`timescale 1ns / 1ps
module scl_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scl_pkg::line_cmd_t push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output scl_pkg::line_cmd_t head_cmd
);
  import scl_pkg::*;

  line_cmd_t             slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hdl/scl_back.sv]
// Back end: applies each classified line to the settings and registers the result.
`timescale 1ns / 1ps
module scl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  scl_pkg::line_cmd_t            head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_event_res,
  output logic                          out_scale_celsius,
  output logic [scl_pkg::PERIOD_W-1:0]  out_sample_period,
  output logic                          out_sampling_stopped
);
  import scl_pkg::*;

  logic                celsius_r, celsius_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                paused_r, paused_nxt;
  logic                out_valid_r, out_valid_nxt;
  event_t              out_ev_r;

  // Take the next line when the output word is empty or leaving this cycle.
  assign pop = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    celsius_nxt = celsius_r;
    period_nxt  = period_r;
    paused_nxt  = paused_r;
    case (head_cmd.ev)
      EV_SCALE:  celsius_nxt = head_cmd.celsius;
      EV_PERIOD: period_nxt  = head_cmd.period;
      EV_STOP:   paused_nxt  = 1'b1;
      EV_START:  paused_nxt  = 1'b0;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      celsius_r   <= 1'b0;
      period_r    <= PERIOD_W'(1);
      paused_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        celsius_r <= celsius_nxt;
        period_r  <= period_nxt;
        paused_r  <= paused_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ev_r             <= head_cmd.ev;
      out_scale_celsius    <= celsius_nxt;
      out_sample_period    <= period_nxt;
      out_sampling_stopped <= paused_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_ev_r;

endmodule

[hdl/sensor_command_line_parser.sv]
// Top level of the byte-serial sensor command line parser.
// Throughput: one byte per cycle; any byte waits while the 2-word line queue is full.
// A newline word is queued at the edge that accepts it, then moved into the output
// register once the output word is empty or being taken.
// Reset: synchronous on rst_n low; Fahrenheit, period 1, running, not halted, queue empty.
// After an OFF line every byte is accepted and dropped until reset.
`timescale 1ns / 1ps
module sensor_command_line_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_cmd_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_event_res,
  output logic                          out_scale_celsius,
  output logic [scl_pkg::PERIOD_W-1:0]  out_sample_period,
  output logic                          out_sampling_stopped
);
  import scl_pkg::*;

  // front end -> queue
  logic      push;
  line_cmd_t push_cmd;
  logic      fifo_full;

  // queue -> back end
  logic      pop;
  logic      head_valid;
  line_cmd_t head_cmd;

  // Front end: per-byte prefix matching, scale letter capture, period
  // accumulation; at a newline it resolves the event and queues one word.
  scl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd_byte (in_cmd_byte),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Decouples byte intake from output stalls.
  scl_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: owns scale/period/pause settings and the output register.
  scl_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head_valid           (head_valid),
    .head_cmd             (head_cmd),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_res        (out_event_res),
    .out_scale_celsius    (out_scale_celsius),
    .out_sample_period    (out_sample_period),
    .out_sampling_stopped (out_sampling_stopped)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the sensor command line parser.
`timescale 1ns / 1ps
module testbench;

  // Byte values and limits used by the testbench.
  localparam logic [7:0] LF        = 8'd10;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam int         LINE_CAP  = 1024;
  localparam int         WATCHDOG  = 5000;
  localparam int         SHOW_MAX  = 10;

  // Keyword slots, one match flag each.
  localparam int KW_SCALE  = 0;
  localparam int KW_PERIOD = 1;
  localparam int KW_STOP   = 2;
  localparam int KW_START  = 3;
  localparam int KW_LOG    = 4;
  localparam int KW_OFF    = 5;
  localparam int KW_COUNT  = 6;
  // STOP, START and OFF must be the whole line; the others are prefixes.
  localparam bit [KW_COUNT-1:0] KW_EXACT = 6'b101100;

  // One expected output word.
  typedef struct packed {
    scl_pkg::event_t                ev;
    logic                           celsius;
    logic [scl_pkg::PERIOD_W-1:0]   period;
    logic                           stopped;
  } report_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_cmd_byte = 8'd0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [2:0]                     out_event_res;
  logic                           out_scale_celsius;
  logic [scl_pkg::PERIOD_W-1:0]   out_sample_period;
  logic                           out_sampling_stopped;

  sensor_command_line_parser u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd_byte          (in_cmd_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_res        (out_event_res),
    .out_scale_celsius    (out_scale_celsius),
    .out_sample_period    (out_sample_period),
    .out_sampling_stopped (out_sampling_stopped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Line tracker state: mirrors the parser, starts at its reset values.
  logic [10:0]                    line_len_m  = '0;
  logic [KW_COUNT-1:0]            match_m     = '1;
  logic [7:0]                     letter_m    = '0;
  logic [31:0]                    acc_m       = '0;
  logic                           celsius_m   = 1'b0;
  logic [scl_pkg::PERIOD_W-1:0]   period_m    = 1;
  logic                           paused_m    = 1'b0;
  logic                           halted_m    = 1'b0;

  report_t    pending_reports[$];
  logic [7:0] line_buf[$];
  report_t    due_rep;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_accepted = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  function automatic string kw_word(input int k);
    case (k)
      KW_SCALE:  return "SCALE=";
      KW_PERIOD: return "PERIOD=";
      KW_STOP:   return "STOP";
      KW_START:  return "START";
      KW_LOG:    return "LOG ";
      default:   return "OFF";
    endcase
  endfunction

  // Keyword still matching and the line is at least as long as it.
  function automatic bit kw_hit(input int k);
    string w;
    w = kw_word(k);
    return match_m[k] && (line_len_m >= w.len());
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == LF);
    return b;
  endfunction

  // Advance the line tracker by one accepted byte; a newline yields a report.
  task automatic track_command_byte(input logic [7:0] b);
    report_t rep;
    string   w;
    int      k;
    if (halted_m) return;
    if (b != LF) begin
      for (k = 0; k < KW_COUNT; k++) begin
        w = kw_word(k);
        if (match_m[k]) begin
          if (line_len_m < w.len()) begin
            if (b != w[line_len_m]) match_m[k] = 1'b0;
          end else if (KW_EXACT[k]) begin
            match_m[k] = 1'b0;
          end
        end
      end
      if (line_len_m == 11'd6) letter_m = b;
      // digits (or anything else) past PERIOD= fold in with 32-bit wrap
      if (line_len_m >= 11'd7) acc_m = acc_m * 32'd10 + {24'd0, b} - 32'd48;
      if (line_len_m < LINE_CAP) line_len_m = line_len_m + 11'd1;
    end else begin
      rep.ev = scl_pkg::EV_IGNORED;
      if (kw_hit(KW_SCALE)) begin
        if (letter_m == "F") begin
          celsius_m = 1'b0;
          rep.ev = scl_pkg::EV_SCALE;
        end else if (letter_m == "C") begin
          celsius_m = 1'b1;
          rep.ev = scl_pkg::EV_SCALE;
        end
      end else if (kw_hit(KW_PERIOD)) begin
        // zero or negative (top bit set) is refused
        if (acc_m == 32'd0 || acc_m[31]) begin
          rep.ev = scl_pkg::EV_REJECTED;
        end else begin
          period_m = acc_m[30:0];
          rep.ev = scl_pkg::EV_PERIOD;
        end
      end else if (kw_hit(KW_STOP)) begin
        paused_m = 1'b1;
        rep.ev = scl_pkg::EV_STOP;
      end else if (kw_hit(KW_START)) begin
        paused_m = 1'b0;
        rep.ev = scl_pkg::EV_START;
      end else if (kw_hit(KW_LOG)) begin
        rep.ev = scl_pkg::EV_LOG;
      end else if (kw_hit(KW_OFF)) begin
        halted_m = 1'b1;
        rep.ev = scl_pkg::EV_OFF;
      end
      rep.celsius = celsius_m;
      rep.period  = period_m;
      rep.stopped = paused_m;
      pending_reports.push_back(rep);
      line_len_m = '0;
      match_m    = '1;
      letter_m   = '0;
      acc_m      = '0;
    end
  endtask

  // Send one input word. Called right after a rising edge, returns right
  // after the edge that accepted it; valid stays high so back-to-back words
  // need no extra assignment.
  task automatic send_cmd_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_accepted++;
    track_command_byte(b);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_cmd_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_cmd_byte(LF);
  endtask

  task automatic append_word(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Always advances at least one edge, so a following valid rise is a new step.
  task automatic wait_for_reports();
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic test_scale_lines();
    send_line("");
    send_line("SCALE=C");
    send_line("SCALE=F");
    send_line("SCALE=");       // six bytes only, no letter
    send_line("SCALE=X");      // other letter leaves the scale alone
    send_line("SCALE=CXYZ");   // only the seventh byte counts
    send_line("scale=F");
  endtask

  task automatic test_period_lines();
    send_line("PERIOD=2147483647");
    send_line("PERIOD=0");
    send_line("PERIOD=2147483648");   // wraps negative
    send_line("PERIOD=4294967297");   // wraps around to 1
    send_line("PERIOD=");
    send_line("PERIOD=1a");           // non-digit folded in like a digit
    // NUL is plain text, not a line end
    send_text("PERIOD=");
    send_cmd_byte(8'h00);
    send_cmd_byte("5");
    send_cmd_byte(LF);
    send_text("PERIOD=");
    send_cmd_byte(8'hFF);
    send_cmd_byte(LF);
    send_line("PERIOD=30");
  endtask

  task automatic test_run_state_lines();
    send_line("STOP");
    send_line("STOPX");
    send_line("STO");
    send_line("START");
    send_line("STARTS");
    send_line("STOP");
  endtask

  task automatic test_log_lines();
    send_line("LOG hello");
    send_line("LOG");
    send_line("LOG ");
    send_line("OFFX");
    send_line("OF");
  endtask

  // Long lines keep matching and accumulating.
  task automatic test_long_lines();
    send_text("LOG ");
    repeat (30) send_cmd_byte(rand_text_byte());
    send_cmd_byte(LF);
    send_text("PERIOD=");
    repeat (20) send_cmd_byte(8'(DIGIT_0 + $urandom_range(9)));
    send_cmd_byte(LF);
    send_text("SCALE=F");
    repeat (20) send_cmd_byte(rand_text_byte());
    send_cmd_byte(LF);
  endtask

  // Mostly well-formed commands with random content, the rest broken
  // prefixes and raw noise. OFF is kept out so the run does not halt early.
  task automatic test_random_stream(input int n_bytes);
    int    start;
    int    sel;
    int    n;
    int    i;
    string w;
    start = bytes_accepted;
    while (bytes_accepted - start < n_bytes) begin
      line_buf.delete();
      sel = $urandom_range(99);
      if (sel < 14) begin
        append_word(kw_word(KW_SCALE));
        n = $urandom_range(9);
        if (n < 4) line_buf.push_back("F");
        else if (n < 8) line_buf.push_back("C");
        else if (n == 8) line_buf.push_back(rand_text_byte());
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 3)) line_buf.push_back(rand_text_byte());
      end else if (sel < 34) begin
        append_word(kw_word(KW_PERIOD));
        n = $urandom_range(10);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(29) == 0) line_buf.push_back(rand_text_byte());
          else line_buf.push_back(8'(DIGIT_0 + $urandom_range(9)));
        end
      end else if (sel < 44) begin
        append_word(kw_word(KW_STOP));
      end else if (sel < 54) begin
        append_word(kw_word(KW_START));
      end else if (sel < 70) begin
        append_word(kw_word(KW_LOG));
        repeat ($urandom_range(10)) line_buf.push_back(rand_text_byte());
      end else if (sel < 85) begin
        // cut or mangled keyword with junk behind it
        w = kw_word($urandom_range(KW_COUNT - 1));
        n = $urandom_range(w.len());
        for (i = 0; i < n; i++) line_buf.push_back(w[i]);
        if (n > 0 && $urandom_range(1) == 1) line_buf[n-1] = rand_text_byte();
        repeat ($urandom_range(3)) line_buf.push_back(rand_text_byte());
      end else begin
        repeat ($urandom_range(12)) line_buf.push_back(rand_text_byte());
      end
      if (line_buf.size() == 3 && line_buf[0] == "O" && line_buf[1] == "F" &&
          line_buf[2] == "F")
        line_buf.push_back("!");
      for (i = 0; i < line_buf.size(); i++) send_cmd_byte(line_buf[i]);
      send_cmd_byte(LF);
    end
  endtask

  // Sender holds off until every pending report has drained.
  task automatic test_pause_until_drained();
    send_line("STOP");
    send_line("PERIOD=12");
    in_valid <= 1'b0;
    wait_for_reports();
    send_line("START");
  endtask

  // OFF halts; everything after it is swallowed without a word out.
  task automatic test_off_halt();
    send_line("OFF");
    send_line("STOP");
    send_line("PERIOD=5");
    repeat (40) send_cmd_byte(8'($urandom_range(255)));
    send_cmd_byte(LF);
  endtask

  // Receiver stalls at random per cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each output word against the oldest pending report.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
          $display("unexpected word: ev=%0d c=%0d per=%0d stop=%0d",
                   out_event_res, out_scale_celsius, out_sample_period,
                   out_sampling_stopped);
      end else begin
        due_rep = pending_reports.pop_front();
        if (out_event_res !== due_rep.ev || out_scale_celsius !== due_rep.celsius ||
            out_sample_period !== due_rep.period ||
            out_sampling_stopped !== due_rep.stopped) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_MAX)
            $display("mismatch: exp ev/c/per/stop %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     due_rep.ev, due_rep.celsius, due_rep.period, due_rep.stopped,
                     out_event_res, out_scale_celsius, out_sample_period,
                     out_sampling_stopped);
        end
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender light gaps, receiver heavy stalls
    send_idle_pct = 32;
    recv_idle_pct = 85;
    test_scale_lines();
    test_period_lines();
    test_run_state_lines();
    test_log_lines();
    test_long_lines();
    test_random_stream(70);
    test_pause_until_drained();

    // swapped: sender sparse, receiver mostly ready
    send_idle_pct = 85;
    recv_idle_pct = 32;
    test_random_stream(70);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(70);
    test_off_halt();

    in_valid <= 1'b0;
    wait_for_reports();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      mismatch_count += pending_reports.size();
      $display("%0d reports never arrived", pending_reports.size());
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
